### sv/dcmb_pkg.sv
// Shared types and constants for the DC motor brake sequencer.
package dcmb_pkg;

   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_GATED      = 3'd1;
   localparam logic [2:0] OP_TIMED      = 3'd2;
   localparam logic [2:0] OP_HARD       = 3'd3;
   localparam logic [2:0] OP_HOLD       = 3'd4;
   localparam logic [2:0] OP_SOFT       = 3'd5;
   localparam logic [2:0] OP_FREE       = 3'd6;
   localparam logic [2:0] OP_REVERSE    = 3'd7;

   localparam logic [2:0] MODE_MOVING   = 3'd0;
   localparam logic [2:0] MODE_TIMED    = 3'd1;
   localparam logic [2:0] MODE_HARD     = 3'd2;
   localparam logic [2:0] MODE_SOFT     = 3'd3;
   localparam logic [2:0] MODE_HOLD     = 3'd4;
   localparam logic [2:0] MODE_FREE     = 3'd5;

   localparam logic [1:0] CSR_UPPER     = 2'd0;
   localparam logic [1:0] CSR_LOWER     = 2'd1;
   localparam logic [1:0] CSR_CW        = 2'd2;

   localparam logic [15:0] HARD_MS      = 16'd100;
   localparam logic [15:0] SOFT_MS      = 16'd1000;
   localparam logic [15:0] REVERSE_MS   = 16'd500;
   localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;
   localparam logic [7:0]  DUTY_FULL    = 8'd255;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [8:0]  speed;
      logic [15:0]        duration_ms;
      logic signed [15:0] encoder_position;
   } req_type;

   typedef struct packed {
      logic       bridge_in1;
      logic       bridge_in2;
      logic [7:0] enable_duty;
      logic [2:0] motor_mode;
      logic       at_upper_limit;
      logic       at_lower_limit;
   } rsp_type;

   typedef struct packed {
      logic       we;
      logic [1:0] index;
      logic [15:0] wdata;
   } csr_type;

endpackage

### sv/dcmb_ifs.sv
// Request and response channel interfaces for the DC motor brake sequencer.
interface dcmb_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic signed [8:0]  speed;
   logic [15:0]        duration_ms;
   logic signed [15:0] encoder_position;

   modport source (output valid, operation, speed, duration_ms, encoder_position,
                   input ready);
   modport sink   (input valid, operation, speed, duration_ms, encoder_position,
                   output ready);
endinterface

interface dcmb_rsp_if;
   logic       valid;
   logic       ready;
   logic       bridge_in1;
   logic       bridge_in2;
   logic [7:0] enable_duty;
   logic [2:0] motor_mode;
   logic       at_upper_limit;
   logic       at_lower_limit;

   modport source (output valid, bridge_in1, bridge_in2, enable_duty, motor_mode,
                   at_upper_limit, at_lower_limit, input ready);
   modport sink   (input valid, bridge_in1, bridge_in2, enable_duty, motor_mode,
                   at_upper_limit, at_lower_limit, output ready);
endinterface

### sv/dcmb_in_stage.sv
// Input register stage holding one request transaction.
module dcmb_in_stage
   import dcmb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   output logic    out_valid,
   input  logic    out_take,
   output req_type out_item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

### sv/dcmb_core.sv
// Motor channel state, limit registers and next-state logic.
module dcmb_core
   import dcmb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    step,
   input  req_type item,
   output rsp_type result
);

   logic signed [15:0] upper_ff, lower_ff;
   logic               cw_ff;
   logic [2:0]         mode_ff, mode_in;
   logic signed [8:0]  speed_ff, speed_in;
   logic [15:0]        period_ff, period_in;
   logic [16:0]        elapsed_ff, elapsed_in;
   logic               upflag_ff, upflag_in;
   logic               loflag_ff, loflag_in;
   logic               in1_ff, in1_in;
   logic               in2_ff, in2_in;
   logic [7:0]         duty_ff, duty_in;

   logic               enc_hi, enc_lo;
   logic               cur_pos, cur_neg, cur_up, cur_low;
   logic               req_pos, req_neg, req_up, req_low;
   logic [16:0]        el_inc;
   logic signed [9:0]  rev_wide;
   logic signed [8:0]  rev_speed;
   logic signed [8:0]  drv_speed;
   logic               drv_en;

   always_comb begin
      enc_hi  = item.encoder_position >= upper_ff;
      enc_lo  = item.encoder_position <= lower_ff;
      cur_neg = speed_ff[8];
      cur_pos = !speed_ff[8] && (speed_ff != 9'sd0);
      cur_up  = cw_ff ? cur_pos : cur_neg;
      cur_low = cw_ff ? cur_neg : cur_pos;
      req_neg = item.speed[8];
      req_pos = !item.speed[8] && (item.speed != 9'sd0);
      req_up  = cw_ff ? req_pos : req_neg;
      req_low = cw_ff ? req_neg : req_pos;
      el_inc  = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 17'd1;
      rev_wide = -{speed_ff[8], speed_ff};
      rev_speed = (rev_wide > 10'sd255) ? 9'sd255 : rev_wide[8:0];
   end

   always_comb begin
      mode_in    = mode_ff;
      speed_in   = speed_ff;
      period_in  = period_ff;
      elapsed_in = elapsed_ff;
      upflag_in  = upflag_ff;
      loflag_in  = loflag_ff;
      in1_in     = in1_ff;
      in2_in     = in2_ff;
      duty_in    = duty_ff;
      drv_en     = 1'b0;
      drv_speed  = item.speed;

      unique case (item.operation)
         OP_TICK: begin
            upflag_in = enc_hi;
            loflag_in = !enc_hi && enc_lo;
            if ((mode_ff == MODE_MOVING || mode_ff == MODE_TIMED) &&
                ((cur_up && upflag_in) || (cur_low && loflag_in))) begin
               mode_in = MODE_HOLD;
               in1_in  = 1'b0;
               in2_in  = 1'b0;
               duty_in = DUTY_FULL;
            end else if (mode_ff == MODE_TIMED || mode_ff == MODE_HARD ||
                         mode_ff == MODE_SOFT) begin
               elapsed_in = el_inc;
               if (el_inc > {1'b0, period_ff}) begin
                  if (mode_ff == MODE_TIMED) begin
                     mode_in    = MODE_HARD;
                     period_in  = HARD_MS;
                     elapsed_in = 17'd0;
                     in1_in     = 1'b1;
                     in2_in     = 1'b1;
                     duty_in    = DUTY_FULL;
                  end else if (mode_ff == MODE_HARD) begin
                     mode_in    = MODE_SOFT;
                     period_in  = SOFT_MS;
                     elapsed_in = 17'd0;
                     in1_in     = 1'b0;
                     in2_in     = 1'b0;
                     duty_in    = DUTY_FULL;
                  end else begin
                     mode_in = MODE_FREE;
                     in1_in  = 1'b0;
                     in2_in  = 1'b0;
                     duty_in = 8'd0;
                  end
               end
            end
         end
         OP_GATED: begin
            drv_en = (req_up && !upflag_ff) || (req_low && !loflag_ff);
         end
         OP_TIMED: begin
            drv_en     = 1'b1;
            period_in  = item.duration_ms;
            elapsed_in = 17'd0;
         end
         OP_HARD: begin
            mode_in    = MODE_HARD;
            period_in  = item.duration_ms;
            elapsed_in = 17'd0;
            in1_in     = 1'b1;
            in2_in     = 1'b1;
            duty_in    = DUTY_FULL;
         end
         OP_HOLD: begin
            mode_in = MODE_HOLD;
            in1_in  = 1'b0;
            in2_in  = 1'b0;
            duty_in = DUTY_FULL;
         end
         OP_SOFT: begin
            mode_in    = MODE_SOFT;
            period_in  = item.duration_ms;
            elapsed_in = 17'd0;
            in1_in     = 1'b0;
            in2_in     = 1'b0;
            duty_in    = DUTY_FULL;
         end
         OP_FREE: begin
            mode_in = MODE_FREE;
            in1_in  = 1'b0;
            in2_in  = 1'b0;
            duty_in = 8'd0;
         end
         OP_REVERSE: begin
            drv_en     = 1'b1;
            drv_speed  = rev_speed;
            period_in  = REVERSE_MS;
            elapsed_in = 17'd0;
         end
         default: begin
         end
      endcase

      if (drv_en) begin
         speed_in = drv_speed;
         mode_in  = (item.operation == OP_GATED) ? MODE_MOVING : MODE_TIMED;
         if (drv_speed[8]) begin
            in1_in  = 1'b0;
            in2_in  = 1'b1;
            duty_in = (drv_speed == -9'sd256) ? DUTY_FULL : 8'((-drv_speed));
         end else begin
            in1_in  = 1'b1;
            in2_in  = 1'b0;
            duty_in = drv_speed[7:0];
         end
      end
   end

   assign result = '{bridge_in1:     in1_in,
                     bridge_in2:     in2_in,
                     enable_duty:    duty_in,
                     motor_mode:     mode_in,
                     at_upper_limit: upflag_in,
                     at_lower_limit: loflag_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= 16'sh7FFF;
         lower_ff <= 16'sh8000;
         cw_ff    <= 1'b1;
      end else if (csr.we) begin
         unique case (csr.index)
            CSR_UPPER: upper_ff <= csr.wdata;
            CSR_LOWER: lower_ff <= csr.wdata;
            CSR_CW:    cw_ff    <= csr.wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_FREE;
         speed_ff   <= 9'sd0;
         period_ff  <= 16'd0;
         elapsed_ff <= 17'd0;
         upflag_ff  <= 1'b0;
         loflag_ff  <= 1'b0;
         in1_ff     <= 1'b0;
         in2_ff     <= 1'b0;
         duty_ff    <= 8'd0;
      end else if (step) begin
         mode_ff    <= mode_in;
         speed_ff   <= speed_in;
         period_ff  <= period_in;
         elapsed_ff <= elapsed_in;
         upflag_ff  <= upflag_in;
         loflag_ff  <= loflag_in;
         in1_ff     <= in1_in;
         in2_ff     <= in2_in;
         duty_ff    <= duty_in;
      end
   end

endmodule

### sv/dcmb_out_stage.sv
// Result register holding one response transaction until taken.
module dcmb_out_stage
   import dcmb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_item,
   output logic    free,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_item
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type item_ff;

   assign free      = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

### sv/dc_motor_brake_sequencer_top.sv
// Top level of the DC motor brake sequencer.
//
//   channel   direction  handshake          contents
//   req_chan  in         valid/ready        operation, speed, duration_ms, encoder_position
//   rsp_chan  out        valid/ready        bridge_in1/2, enable_duty, motor_mode, limit flags
//   csr_*     in         write enable only  upper/lower position limit, clockwise_is_positive
//
// One transaction per cycle sustained while the response channel is not stalled.
// The request register feeds the next-state logic, which loads the response register.
// Reset is synchronous and active high; no clearing pass.
// A stalled response holds the request register, which then drops ready.
module dc_motor_brake_sequencer_top
   import dcmb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dcmb_req_if.sink    req_chan,
   dcmb_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   req_type in_item, stage_item;
   rsp_type next_rsp, out_item;
   csr_type csr;
   logic    stage_valid, out_free, step;

   assign in_item = '{operation:        req_chan.operation,
                      speed:            req_chan.speed,
                      duration_ms:      req_chan.duration_ms,
                      encoder_position: req_chan.encoder_position};
   assign csr     = '{we: csr_we, index: csr_index, wdata: csr_wdata};
   assign step    = stage_valid && out_free;

   dcmb_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_item   (in_item),
      .out_valid (stage_valid),
      .out_take  (step),
      .out_item  (stage_item)
   );

   dcmb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .step   (step),
      .item   (stage_item),
      .result (next_rsp)
   );

   dcmb_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .load_item (next_rsp),
      .free      (out_free),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   assign rsp_chan.bridge_in1     = out_item.bridge_in1;
   assign rsp_chan.bridge_in2     = out_item.bridge_in2;
   assign rsp_chan.enable_duty    = out_item.enable_duty;
   assign rsp_chan.motor_mode     = out_item.motor_mode;
   assign rsp_chan.at_upper_limit = out_item.at_upper_limit;
   assign rsp_chan.at_lower_limit = out_item.at_lower_limit;

endmodule
